// ===== src/a2p_pkg.sv =====
`timescale 1ns / 1ps

package a2p_pkg;

    // Quotient of the ratio divide: min * 2^16 / max, 0..65536
    localparam int Q_BITS = 17;
    // Ratio r in Q1.15, 0..32768
    localparam int R_BITS = 16;
    localparam int R_FRAC = 15;
    // x2 = r*r in Q30, 0..2^30
    localparam int X2_BITS = 31;
    localparam int Q_FRAC = 30;
    // Horner accumulator, signed Q30
    localparam int ACC_BITS = 32;
    localparam int MAG_BITS = 31;
    localparam int PROD_BITS = MAG_BITS + X2_BITS;
    localparam int PROD2_BITS = MAG_BITS + R_BITS;
    localparam int HORNER_STEPS = 7;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    typedef logic signed [ACC_BITS-1:0] coef_t;

    // Chebyshev fit coefficients, Q30, index k multiplies x2^k
    localparam coef_t COEF [0:HORNER_STEPS] = '{
        -32'sd357911082,
         32'sd214667662,
        -32'sd152498945,
         32'sd114211276,
        -32'sd80481727,
         32'sd45728098,
        -32'sd17185270,
         32'sd3043049
    };

    // Sign and octant info that travels beside the data
    typedef struct packed {
        logic undef;
        logic nneg;
        logic dneg;
        logic invert;
    } oct_t;

endpackage

// ===== src/a2p_div.sv =====
`timescale 1ns / 1ps

module a2p_div #(
    parameter int INPUT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [INPUT_BITS-1:0] numerator,
    input  logic signed [INPUT_BITS-1:0] denominator,
    output logic                         out_valid,
    output logic [a2p_pkg::Q_BITS-1:0]   out_q,
    output a2p_pkg::oct_t                out_oct
);
    import a2p_pkg::*;

    // Stage 0 sorts magnitudes, stages 1..Q_BITS produce one quotient bit each
    localparam int NS = Q_BITS + 1;

    logic [NS-1:0]         v_reg;
    logic [INPUT_BITS-1:0] rem_reg [0:NS-2];
    logic [INPUT_BITS-1:0] hi_reg  [0:NS-2];
    logic [Q_BITS-1:0]     q_reg   [0:NS-1];
    oct_t                  oct_reg [0:NS-1];

    logic [INPUT_BITS-1:0] num_u;
    logic [INPUT_BITS-1:0] den_u;
    logic                  nneg;
    logic                  dneg;
    logic [INPUT_BITS-1:0] nmag;
    logic [INPUT_BITS-1:0] dmag;
    logic                  invert;
    oct_t                  oct_next;

    assign num_u  = numerator;
    assign den_u  = denominator;
    assign nneg   = num_u[INPUT_BITS-1];
    assign dneg   = den_u[INPUT_BITS-1];
    // most negative input maps to 2^(INPUT_BITS-1), which fits unsigned
    assign nmag   = nneg ? ({INPUT_BITS{1'b0}} - num_u) : num_u;
    assign dmag   = dneg ? ({INPUT_BITS{1'b0}} - den_u) : den_u;
    assign invert = dmag < nmag;

    always_comb
    begin
        oct_next.undef  = (nmag == '0) && (dmag == '0);
        oct_next.nneg   = nneg;
        oct_next.dneg   = dneg;
        oct_next.invert = invert;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            rem_reg[0] <= invert ? dmag : nmag;
            hi_reg[0]  <= invert ? nmag : dmag;
            q_reg[0]   <= '0;
            oct_reg[0] <= oct_next;
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_step
        logic [INPUT_BITS:0]   trial;
        logic [INPUT_BITS:0]   diff;
        logic                  ge;

        // first step compares min against max unshifted (ratio of 1.0)
        if (s == 1)
        begin : g_first
            assign trial = {1'b0, rem_reg[s-1]};
        end
        else
        begin : g_shift
            assign trial = {rem_reg[s-1], 1'b0};
        end

        assign diff = trial - {1'b0, hi_reg[s-1]};
        assign ge   = !diff[INPUT_BITS];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en && v_reg[s-1])
            begin
                q_reg[s]   <= {q_reg[s-1][Q_BITS-2:0], ge};
                oct_reg[s] <= oct_reg[s-1];
            end
        end

        if (s < NS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en && v_reg[s-1])
                begin
                    rem_reg[s] <= ge ? diff[INPUT_BITS-1:0] : trial[INPUT_BITS-1:0];
                    hi_reg[s]  <= hi_reg[s-1];
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_q     = q_reg[NS-1];
    assign out_oct   = oct_reg[NS-1];

endmodule

// ===== src/a2p_poly.sv =====
`timescale 1ns / 1ps

module a2p_poly #(
    parameter int ANGLE_FRACTION_BITS = 13
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [a2p_pkg::Q_BITS-1:0]     in_q,
    input  a2p_pkg::oct_t                  in_oct,
    output logic                           out_valid,
    output logic [ANGLE_FRACTION_BITS+1:0] out_pa,
    output a2p_pkg::oct_t                  out_oct
);
    import a2p_pkg::*;

    localparam int F  = ANGLE_FRACTION_BITS;
    localparam int PW = F + 2;
    // 0 round ratio, 1 square, 2..15 Horner, 16..17 times x2,
    // 18..19 times r plus r, 20 scale to angle units
    localparam int NP       = 21;
    localparam int ST_T     = 2 + 2 * HORNER_STEPS + 1;
    localparam int ST_PR    = ST_T + 1;
    localparam int ST_P     = ST_PR + 1;
    localparam int ST_PA    = ST_P + 1;

    logic [NP-1:0]            v_reg;
    oct_t                     oct_reg   [0:NP-1];
    logic [R_BITS-1:0]        r_reg     [0:ST_P-1];
    logic [X2_BITS-1:0]       x2_reg    [1:2*HORNER_STEPS+1];
    logic [PROD_BITS-1:0]     prod_reg  [0:HORNER_STEPS];
    logic                     psign_reg [0:HORNER_STEPS];
    logic signed [ACC_BITS-1:0] acc_reg [0:HORNER_STEPS-1];
    logic [MAG_BITS-1:0]      tmag_reg;
    logic                     tsign_reg;
    logic [PROD2_BITS-1:0]    prod2_reg;
    logic                     sign2_reg;
    logic [ACC_BITS-1:0]      p_reg;
    logic [PW-1:0]            pa_reg;

    // valid and octant info follow every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    logic [Q_BITS-1:0] q_rnd;
    assign q_rnd = in_q + {{(Q_BITS-1){1'b0}}, 1'b1};

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            oct_reg[0] <= in_oct;
            r_reg[0]   <= q_rnd[R_BITS:1];
        end
    end

    for (genvar i = 1; i < NP; i++)
    begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en && v_reg[i-1])
            begin
                oct_reg[i] <= oct_reg[i-1];
            end
        end
    end

    for (genvar i = 1; i < ST_P; i++)
    begin : g_r
        always_ff @(posedge clk)
        begin
            if (en && v_reg[i-1])
            begin
                r_reg[i] <= r_reg[i-1];
            end
        end
    end

    // r <= 2^15, so r*r <= 2^30 fits X2_BITS
    logic [X2_BITS-1:0] sq;
    assign sq = X2_BITS'(r_reg[0]) * X2_BITS'(r_reg[0]);

    always_ff @(posedge clk)
    begin
        if (en && v_reg[0])
        begin
            x2_reg[1] <= sq;
        end
    end

    for (genvar i = 2; i <= 2 * HORNER_STEPS + 1; i++)
    begin : g_x2
        always_ff @(posedge clk)
        begin
            if (en && v_reg[i-1])
            begin
                x2_reg[i] <= x2_reg[i-1];
            end
        end
    end

    // Each Horner step: multiply stage, then round-and-add stage.
    // The last multiply (j = HORNER_STEPS) forms acc * x2 with no add.
    for (genvar j = 0; j <= HORNER_STEPS; j++)
    begin : g_horner
        localparam int M = 2 + 2 * j;
        logic signed [ACC_BITS-1:0] acc_in;
        logic [MAG_BITS-1:0]        mag;

        if (j == 0)
        begin : g_c
            assign acc_in = COEF[HORNER_STEPS];
        end
        else
        begin : g_a
            assign acc_in = acc_reg[j-1];
        end

        assign mag = acc_in[ACC_BITS-1] ? MAG_BITS'(-acc_in) : MAG_BITS'(acc_in);

        always_ff @(posedge clk)
        begin
            if (en && v_reg[M-1])
            begin
                prod_reg[j]  <= PROD_BITS'(mag) * PROD_BITS'(x2_reg[M-1]);
                psign_reg[j] <= acc_in[ACC_BITS-1];
            end
        end

        if (j < HORNER_STEPS)
        begin : g_add
            logic [PROD_BITS:0]         rnd;
            logic [ACC_BITS-1:0]        qm;
            logic signed [ACC_BITS-1:0] term;

            // round half away from zero on the magnitude
            assign rnd  = {1'b0, prod_reg[j]} + ((PROD_BITS+1)'(1) << (Q_FRAC - 1));
            assign qm   = rnd[Q_FRAC +: ACC_BITS];
            assign term = psign_reg[j] ? -signed'(qm) : signed'(qm);

            always_ff @(posedge clk)
            begin
                if (en && v_reg[M])
                begin
                    acc_reg[j] <= COEF[HORNER_STEPS-1-j] + term;
                end
            end
        end
    end

    logic [PROD_BITS:0] rnd_t;
    assign rnd_t = {1'b0, prod_reg[HORNER_STEPS]} + ((PROD_BITS+1)'(1) << (Q_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (en && v_reg[ST_T-1])
        begin
            tmag_reg  <= rnd_t[Q_FRAC +: MAG_BITS];
            tsign_reg <= psign_reg[HORNER_STEPS];
        end
    end

    // times r*2^15 is done as times r, then rounding at bit 15
    always_ff @(posedge clk)
    begin
        if (en && v_reg[ST_PR-1])
        begin
            prod2_reg <= PROD2_BITS'(tmag_reg) * PROD2_BITS'(r_reg[ST_PR-1]);
            sign2_reg <= tsign_reg;
        end
    end

    logic [PROD2_BITS:0] rnd2;
    logic [ACC_BITS-1:0] u;
    logic [ACC_BITS:0]   rq;
    logic [ACC_BITS:0]   p_sum;

    assign rnd2  = {1'b0, prod2_reg} + ((PROD2_BITS+1)'(1) << (R_FRAC - 1));
    assign u     = rnd2[R_FRAC +: ACC_BITS];
    assign rq    = (ACC_BITS+1)'({r_reg[ST_P-1], {R_FRAC{1'b0}}});
    assign p_sum = sign2_reg ? (rq - {1'b0, u}) : (rq + {1'b0, u});

    always_ff @(posedge clk)
    begin
        if (en && v_reg[ST_P-1])
        begin
            // clamp negative results to zero
            p_reg <= p_sum[ACC_BITS] ? '0 : p_sum[ACC_BITS-1:0];
        end
    end

    logic [ACC_BITS:0] p_rnd;
    assign p_rnd = {1'b0, p_reg} + ((ACC_BITS+1)'(1) << (Q_FRAC - 1 - F));

    always_ff @(posedge clk)
    begin
        if (en && v_reg[ST_PA-1])
        begin
            pa_reg <= p_rnd[Q_FRAC-F +: PW];
        end
    end

    assign out_valid = v_reg[NP-1];
    assign out_pa    = pa_reg;
    assign out_oct   = oct_reg[NP-1];

endmodule

// ===== src/a2p_obuf.sv =====
`timescale 1ns / 1ps

module a2p_obuf #(
    parameter int WIDTH = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    // two-entry buffer: the pipeline keeps moving while one result waits
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [WIDTH-1:0] mem_reg [0:1];
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign full      = count_reg == 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("transfer into full output buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

endmodule

// ===== src/atan2_octant_polynomial_core.sv =====
`timescale 1ns / 1ps

// Four-quadrant arctangent, angle = atan2(numerator, denominator).
// Input channel: in_valid / in_ready with numerator and denominator
// (signed, INPUT_BITS). A transfer happens on a clock edge where both are high.
// Output channel: out_valid / out_ready with angle (signed radians,
// ANGLE_FRACTION_BITS fraction bits, -pi..pi) and undefined (0/0, angle 0).
// Pipeline: the input transfer edge loads the first of 40 register stages
// (18 divider stages, a magnitude sort then one quotient bit each;
// 21 polynomial stages, a multiply and a round/add per Horner step;
// one output buffer stage).
// Throughput: one item per cycle while out_ready stays high.
// Stall: the whole pipeline advances together; a two-entry output buffer
// takes what leaves it, so one more item is accepted while a result waits.
// in_ready drops only when both buffer entries hold results.
// Reset: rst_n clears all valid bits and the buffer; no result is pending.
module atan2_octant_polynomial_core #(
    parameter int INPUT_BITS          = 16,
    parameter int ANGLE_FRACTION_BITS = 13
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [INPUT_BITS-1:0]       numerator,
    input  logic signed [INPUT_BITS-1:0]       denominator,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ANGLE_FRACTION_BITS+2:0] angle,
    output logic                               undefined
);
    import a2p_pkg::*;

    localparam int F  = ANGLE_FRACTION_BITS;
    localparam int AB = F + 3;
    localparam logic [63:0] PI_A64   = (PI_Q62 + (64'd1 << (61 - F))) >> (62 - F);
    localparam logic [63:0] HALF_A64 = (PI_Q62 + (64'd1 << (62 - F))) >> (63 - F);
    localparam logic signed [AB:0] PI_A   = (AB+1)'(PI_A64);
    localparam logic signed [AB:0] HALF_A = (AB+1)'(HALF_A64);

    logic                 en;
    logic                 obuf_full;
    logic                 div_valid;
    logic [Q_BITS-1:0]    div_q;
    oct_t                 div_oct;
    logic                 poly_valid;
    logic [F+1:0]         poly_pa;
    oct_t                 poly_oct;

    assign en       = !obuf_full;
    assign in_ready = en;

    a2p_div #(
        .INPUT_BITS(INPUT_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .numerator   (numerator),
        .denominator (denominator),
        .out_valid   (div_valid),
        .out_q       (div_q),
        .out_oct     (div_oct)
    );

    a2p_poly #(
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_q      (div_q),
        .in_oct    (div_oct),
        .out_valid (poly_valid),
        .out_pa    (poly_pa),
        .out_oct   (poly_oct)
    );

    // octant correction
    logic signed [AB:0] pa_s;
    logic signed [AB:0] a_s;
    logic signed [AB:0] ang_w;
    logic [AB-1:0]      ang_out;

    assign pa_s = (AB+1)'(poly_pa);
    assign a_s  = (poly_oct.nneg != poly_oct.dneg) ? -pa_s : pa_s;

    always_comb
    begin
        if (poly_oct.invert)
        begin
            ang_w = (poly_oct.nneg ? -HALF_A : HALF_A) - a_s;
        end
        else if (!poly_oct.dneg)
        begin
            ang_w = a_s;
        end
        else
        begin
            ang_w = poly_oct.nneg ? (a_s - PI_A) : (a_s + PI_A);
        end
    end

    assign ang_out = poly_oct.undef ? '0 : ang_w[AB-1:0];

    logic [AB:0] obuf_out;

    a2p_obuf #(
        .WIDTH(AB + 1)
    ) u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && poly_valid),
        .push_data ({poly_oct.undef, ang_out}),
        .full      (obuf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (obuf_out)
    );

    assign angle     = obuf_out[AB-1:0];
    assign undefined = obuf_out[AB];

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && undefined) |-> (angle == '0))
        else $error("undefined result with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((AB+1)'(angle) <= PI_A && (AB+1)'(angle) >= -PI_A))
        else $error("angle outside -pi..pi");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

// ===== test/tb_atan2_octant_polynomial_core.sv =====
`timescale 1ns / 1ps

module tb_atan2_octant_polynomial_core;

    localparam int IN_BITS    = 16;
    localparam int ANGLE_FRAC = 13;
    localparam int ANGLE_W    = ANGLE_FRAC + 3;

    localparam longint unsigned PI_Q62 = 64'hC90FDAA22168C235;
    localparam longint PI_UNITS =
        longint'((PI_Q62 + (64'd1 << (61 - ANGLE_FRAC))) >> (62 - ANGLE_FRAC));
    localparam longint HALF_PI_UNITS =
        longint'((PI_Q62 + (64'd1 << (62 - ANGLE_FRAC))) >> (63 - ANGLE_FRAC));

    typedef struct packed {
        logic signed [IN_BITS-1:0] num;
        logic signed [IN_BITS-1:0] den;
        logic signed [ANGLE_W-1:0] angle;
        logic                      undefined;
    } angle_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [IN_BITS-1:0] numerator;
    logic signed [IN_BITS-1:0] denominator;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [ANGLE_W-1:0] angle;
    logic                      undefined;

    angle_result_t angle_expect_q[$];
    int            mismatch_cnt = 0;

    // receiver stall pattern state
    int            stall_mode = 0;
    int            stall_span = 0;
    int unsigned   rx_tick = 0;

    atan2_octant_polynomial_core #(
        .INPUT_BITS          (IN_BITS),
        .ANGLE_FRACTION_BITS (ANGLE_FRAC)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .numerator   (numerator),
        .denominator (denominator),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle       (angle),
        .undefined   (undefined)
    );

    always #5 clk = ~clk;

    // Chebyshev coefficients, Q30, index k multiplies x^(2k)
    function automatic longint horner_coef(input int k);
        case (k)
            0:       return -64'sd357911082;
            1:       return 64'sd214667662;
            2:       return -64'sd152498945;
            3:       return 64'sd114211276;
            4:       return -64'sd80481727;
            5:       return 64'sd45728098;
            6:       return -64'sd17185270;
            default: return 64'sd3043049;
        endcase
    endfunction

    // Q30 product, rounded half away from zero
    function automatic longint q30_mul(input longint a, input longint unsigned b);
        longint unsigned m;
        longint unsigned q;
        m = (a < 0) ? longint'(-a) : a;
        q = (m * b + (64'd1 << 29)) >> 30;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic angle_result_t atan2_predict(input logic signed [IN_BITS-1:0] num,
                                                    input logic signed [IN_BITS-1:0] den);
        angle_result_t     res;
        longint            sn, sd, acc, p, a, ang;
        longint unsigned   nmag, dmag, lo, hi, ratio, x2, rq, pa;
        logic              swap;
        int                k;
        res.num       = num;
        res.den       = den;
        res.angle     = '0;
        res.undefined = 1'b0;
        sn   = longint'(num);
        sd   = longint'(den);
        nmag = (sn < 0) ? -sn : sn;
        dmag = (sd < 0) ? -sd : sd;
        if (nmag == 0 && dmag == 0) begin
            res.undefined = 1'b1;
            return res;
        end
        swap  = dmag < nmag;
        lo    = swap ? dmag : nmag;
        hi    = swap ? nmag : dmag;
        ratio = ((lo << 16) / hi + 64'd1) >> 1;
        x2    = ratio * ratio;
        rq    = ratio << 15;
        acc   = horner_coef(7);
        for (k = 6; k >= 0; k--)
            acc = horner_coef(k) + q30_mul(acc, x2);
        p = longint'(rq) + q30_mul(q30_mul(acc, x2), rq);
        if (p < 0)
            p = 0;
        pa = (longint'(p) + (64'd1 << (29 - ANGLE_FRAC))) >> (30 - ANGLE_FRAC);
        a  = ((sn < 0) != (sd < 0)) ? -longint'(pa) : longint'(pa);
        if (swap)
            ang = ((sn < 0) ? -HALF_PI_UNITS : HALF_PI_UNITS) - a;
        else if (sd >= 0)
            ang = a;
        else
            ang = (sn < 0) ? a - PI_UNITS : a + PI_UNITS;
        res.angle = ang[ANGLE_W-1:0];
        return res;
    endfunction

    task automatic send_item(input logic signed [IN_BITS-1:0] num,
                             input logic signed [IN_BITS-1:0] den);
        numerator   <= num;
        denominator <= den;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        angle_expect_q.push_back(atan2_predict(num, den));
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (angle_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_operands(output logic signed [IN_BITS-1:0] num,
                                   output logic signed [IN_BITS-1:0] den);
        int m, o, sel;
        sel = $urandom_range(0, 9);
        case (sel)
            4: begin
                m = $urandom_range(0, 16);
                o = $urandom_range(0, 16);
                num = IN_BITS'(m - 8);
                den = IN_BITS'(o - 8);
            end
            5: begin
                // near-equal magnitudes, ratio close to one
                m = $urandom_range(1, 32767);
                o = m + $urandom_range(0, 2) - 1;
                if (o > 32767)
                    o = 32767;
                num = IN_BITS'($urandom_range(0, 1) ? -m : m);
                den = IN_BITS'($urandom_range(0, 1) ? -o : o);
                if ($urandom_range(0, 1)) begin
                    num = den;
                    den = IN_BITS'($urandom_range(0, 1) ? -m : m);
                end
            end
            6: begin
                m = $urandom;
                if ($urandom_range(0, 1)) begin
                    num = '0;
                    den = m[IN_BITS-1:0];
                end else begin
                    num = m[IN_BITS-1:0];
                    den = '0;
                end
            end
            7: begin
                m = $urandom;
                o = $urandom_range(0, 1) ? -32768 : 32767;
                if ($urandom_range(0, 1)) begin
                    num = IN_BITS'(o);
                    den = m[IN_BITS-1:0];
                end else begin
                    num = m[IN_BITS-1:0];
                    den = IN_BITS'(o);
                end
            end
            8, 9: begin
                m = $urandom_range(0, 32767) >> $urandom_range(0, 14);
                o = $urandom_range(0, 32767) >> $urandom_range(0, 14);
                num = IN_BITS'($urandom_range(0, 1) ? -m : m);
                den = IN_BITS'($urandom_range(0, 1) ? -o : o);
            end
            default: begin
                m = $urandom;
                num = m[IN_BITS-1:0];
                den = m[2*IN_BITS-1:IN_BITS];
            end
        endcase
    endtask

    task automatic test_directed();
        send_item(16'sd0, 16'sd0);             // zero over zero
        send_item(16'sd0, 16'sd1);
        send_item(16'sd0, -16'sd1);            // +pi on the negative axis
        send_item(16'sd1, 16'sd0);
        send_item(-16'sd1, 16'sd0);
        send_item(16'sd100, 16'sd100);         // equal magnitudes, all quadrants
        send_item(16'sd100, -16'sd100);
        send_item(-16'sd100, 16'sd100);
        send_item(-16'sd100, -16'sd100);
        send_item(-16'sd32768, -16'sd32768);   // most negative inputs
        send_item(-16'sd32768, 16'sd32767);
        send_item(16'sd32767, -16'sd32768);
        send_item(-16'sd32768, 16'sd0);
        send_item(16'sd0, -16'sd32768);
        send_item(16'sd32767, 16'sd32767);
        send_item(16'sd32767, -16'sd32767);
        send_item(16'sd1, 16'sd32767);
        send_item(-16'sd1, -16'sd32767);
        send_item(16'sd32767, 16'sd1);
        send_item(16'sd1, -16'sd32768);
        send_item(-16'sd32768, 16'sd1);
        send_item(16'sd12345, -16'sd23456);
        send_item(-16'sd20000, 16'sd7);
        send_item(16'sd5, -16'sd3);
        wait_results_drained();
    endtask

    // sender never idles; receiver pattern still applies
    task automatic test_back_to_back();
        logic signed [IN_BITS-1:0] num, den;
        int i;
        for (i = 0; i < 150; i++) begin
            random_operands(num, den);
            send_item(num, den);
        end
    endtask

    task automatic test_random_bursts();
        logic signed [IN_BITS-1:0] num, den;
        int i, burst_left;
        burst_left = $urandom_range(1, 40);
        for (i = 0; i < 976; i++) begin
            random_operands(num, den);
            send_item(num, den);
            if (i % 250 == 249)
                wait_results_drained();
            else if (burst_left == 0) begin
                sender_gap($urandom_range(0, 8));
                burst_left = $urandom_range(1, 40);
            end else
                burst_left--;
        end
    endtask

    // receiver: stall mode changes after each random stall span
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(50, 300);
        end else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (rx_tick[3:0] < 4'd10);
        endcase
    end

    always @(posedge clk) begin : result_check
        angle_result_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (angle_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with nothing pending: angle %0d undefined %0b",
                             $realtime, angle, undefined);
            end else begin
                exp_r = angle_expect_q.pop_front();
                if (angle !== exp_r.angle || undefined !== exp_r.undefined) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display(
                            "%0t: atan2(%0d, %0d) angle/undefined exp %0d/%0b got %0d/%0b",
                            $realtime, exp_r.num, exp_r.den, exp_r.angle,
                            exp_r.undefined, angle, undefined);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        numerator   <= '0;
        denominator <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_random_bursts();

        wait_results_drained();
        // catch any stray transfer after the last expected result
        repeat (60) @(posedge clk);
        if (mismatch_cnt == 0 && angle_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
